/* design/iopc_pkg.sv */
// Package: shared types and register map constants of the performance counter unit.
`timescale 1ns / 1ps

package iopc_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } iopc_kind_e;

  // Word offsets (byte offset divided by four).
  localparam logic [7:0] IPSR_W   = 8'h15;
  localparam logic [7:0] OVF_W    = 8'h16;
  localparam logic [7:0] INH_W    = 8'h17;
  localparam logic [7:0] CYC_LO_W = 8'h18;
  localparam logic [7:0] CYC_HI_W = 8'h19;
  localparam logic [7:0] CTR_W    = 8'h1A;
  localparam logic [7:0] EVT_W    = 8'h58;

  localparam int unsigned PMIP_BIT = 2;
  localparam int unsigned SEL_BITS = 63;
  localparam int unsigned ID_BITS  = 15;
  localparam int unsigned NUM_IDS  = 8;

  typedef struct packed {
    logic wr_lo;
    logic wr_hi;
    logic inc;
  } iopc_ctl_t;

  typedef struct packed {
    logic ctr_wr_lo;
    logic ctr_wr_hi;
    logic sel_wr_lo;
    logic sel_wr_hi;
    logic tick;
    logic inhibit;
  } iopc_slot_ctl_t;

endpackage

/* design/iopc_counter.sv */
// Counter register with 32-bit half writes and wrap detection.
`timescale 1ns / 1ps

module iopc_counter
  import iopc_pkg::*;
#(
  parameter int unsigned WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iopc_ctl_t        ctl_i,
  input  logic [31:0]      wdata_i,
  output logic [WIDTH-1:0] count_o,
  output logic             wrap_o
);

  logic [WIDTH-1:0] count_q, count_d;
  logic [63:0]      wide;
  logic [63:0]      merged;

  always_comb begin
    wide    = 64'(count_q);
    merged  = ctl_i.wr_hi ? {wdata_i, wide[31:0]} : {wide[63:32], wdata_i};
    count_d = count_q;
    if (ctl_i.wr_lo || ctl_i.wr_hi) begin
      count_d = merged[WIDTH-1:0];
    end else if (ctl_i.inc) begin
      count_d = count_q + WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign wrap_o  = ctl_i.inc && (&count_q);

endmodule

/* design/iopc_evt_slot.sv */
// Event counter slot: counter, event selector with overflow flag, event match.
`timescale 1ns / 1ps

module iopc_evt_slot
  import iopc_pkg::*;
#(
  parameter int unsigned WIDTH = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iopc_slot_ctl_t      ctl_i,
  input  logic [31:0]         wdata_i,
  input  logic [NUM_IDS-1:0]  hits_i,
  output logic [WIDTH-1:0]    count_o,
  output logic [SEL_BITS-1:0] sel_o,
  output logic                ovf_o,
  output logic                set_pend_o
);

  logic [SEL_BITS-1:0] sel_q, sel_d;
  logic                ovf_q, ovf_d;
  logic [ID_BITS-1:0]  id;
  logic                match;
  logic                wrap;
  iopc_ctl_t           ctr_ctl;

  always_comb begin
    id    = sel_q[ID_BITS-1:0];
    match = (id != '0) && (id <= ID_BITS'(NUM_IDS)) && hits_i[3'(id[3:0] - 4'd1)];
    ctr_ctl.wr_lo = ctl_i.ctr_wr_lo;
    ctr_ctl.wr_hi = ctl_i.ctr_wr_hi;
    ctr_ctl.inc   = ctl_i.tick && !ctl_i.inhibit && match;
  end

  iopc_counter #(
    .WIDTH(WIDTH)
  ) u_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctr_ctl),
    .wdata_i(wdata_i),
    .count_o(count_o),
    .wrap_o (wrap)
  );

  always_comb begin
    sel_d = sel_q;
    ovf_d = ovf_q;
    if (ctl_i.sel_wr_lo) begin
      sel_d[31:0] = wdata_i;
    end else if (ctl_i.sel_wr_hi) begin
      sel_d[SEL_BITS-1:32] = wdata_i[30:0];
      ovf_d                = wdata_i[31];
    end else if (wrap) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      ovf_q <= ovf_d;
    end
  end

  assign sel_o      = sel_q;
  assign ovf_o      = ovf_q;
  assign set_pend_o = wrap && !ovf_q;

endmodule

/* design/iommu_perf_counter_unit.sv */
// Performance monitor counters of an IOMMU: cycle counter, event counters, overflow and irq.
//
// Each item is a register read, a register write or one clock tick with its event hits.
// One item is accepted per cycle while the output side does not stall: the item is
// held in an input register, then a single pass updates every counter in parallel and
// loads the result register. The result register decouples the output side, so the
// next item is taken while a result still waits for its transfer.
`timescale 1ns / 1ps

module iommu_perf_counter_unit
  import iopc_pkg::*;
#(
  parameter int unsigned NUM_CTRS           = 8,
  parameter int unsigned EVENT_COUNTER_BITS = 48,
  parameter int unsigned CYCLE_COUNTER_BITS = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  event_hits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_pending_o
);

  localparam int unsigned NumEvt   = NUM_CTRS - 1;
  localparam int unsigned EvtSlots = (NUM_CTRS > 1) ? NUM_CTRS - 1 : 1;

  logic        s1_valid_q;
  iopc_kind_e  kind_q;
  logic [7:0]  word_q;
  logic [31:0] data_q;
  logic [7:0]  hits_q;

  logic        out_valid_q;
  logic [31:0] rd_q, rd_d;
  logic        irq_q;

  logic        out_free;
  logic        exec;
  logic        is_wr;
  logic        is_tick;

  logic [NUM_CTRS-1:0] inh_q, inh_d;
  logic                pend_q, pend_d;
  logic                cyc_ovf_q, cyc_ovf_d;

  iopc_ctl_t                     cyc_ctl;
  logic [CYCLE_COUNTER_BITS-1:0] cyc_count;
  logic                          cyc_wrap;
  logic [63:0]                   cyc64;

  logic       in_ctr, in_evt;
  logic [6:0] ctr_k, evt_k;

  iopc_slot_ctl_t              slot_ctl  [EvtSlots];
  logic [EVENT_COUNTER_BITS-1:0] slot_cnt [EvtSlots];
  logic [SEL_BITS-1:0]         slot_sel  [EvtSlots];
  logic [EvtSlots-1:0]         slot_ovf;
  logic [EvtSlots-1:0]         slot_set;
  logic [31:0]                 ovf_sum;

  assign out_free   = !out_valid_q || out_ready_i;
  assign exec       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign is_wr      = exec && (kind_q == KIND_WRITE);
  assign is_tick    = exec && (kind_q == KIND_TICK);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= iopc_kind_e'(kind_i);
      word_q <= reg_offset_i[9:2];
      data_q <= write_data_i;
      hits_q <= event_hits_i;
    end
  end

  // Address decode.
  always_comb begin
    in_ctr = (word_q >= CTR_W) && (word_q < EVT_W);
    in_evt = (word_q >= EVT_W);
    ctr_k  = 7'((word_q - CTR_W) >> 1);
    evt_k  = 7'((word_q - EVT_W) >> 1);
  end

  // Cycle counter.
  always_comb begin
    cyc_ctl.wr_lo = is_wr && (word_q == CYC_LO_W);
    cyc_ctl.wr_hi = is_wr && (word_q == CYC_HI_W);
    cyc_ctl.inc   = is_tick && !inh_q[0];
  end

  iopc_counter #(
    .WIDTH(CYCLE_COUNTER_BITS)
  ) u_cyc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cyc_ctl),
    .wdata_i(data_q),
    .count_o(cyc_count),
    .wrap_o (cyc_wrap)
  );

  assign cyc64 = {cyc_ovf_q, 63'(cyc_count)};

  // Event counter slots.
  for (genvar k = 0; k < EvtSlots; k++) begin : g_slot
    if (k < NumEvt) begin : g_on
      always_comb begin
        slot_ctl[k].ctr_wr_lo = is_wr && in_ctr && (ctr_k == 7'(k)) && !word_q[0];
        slot_ctl[k].ctr_wr_hi = is_wr && in_ctr && (ctr_k == 7'(k)) && word_q[0];
        slot_ctl[k].sel_wr_lo = is_wr && in_evt && (evt_k == 7'(k)) && !word_q[0];
        slot_ctl[k].sel_wr_hi = is_wr && in_evt && (evt_k == 7'(k)) && word_q[0];
        slot_ctl[k].tick      = is_tick;
        slot_ctl[k].inhibit   = inh_q[k+1];
      end

      iopc_evt_slot #(
        .WIDTH(EVENT_COUNTER_BITS)
      ) u_slot (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (slot_ctl[k]),
        .wdata_i   (data_q),
        .hits_i    (hits_q),
        .count_o   (slot_cnt[k]),
        .sel_o     (slot_sel[k]),
        .ovf_o     (slot_ovf[k]),
        .set_pend_o(slot_set[k])
      );
    end else begin : g_off
      assign slot_ctl[k] = '0;
      assign slot_cnt[k] = '0;
      assign slot_sel[k] = '0;
      assign slot_ovf[k] = 1'b0;
      assign slot_set[k] = 1'b0;
    end
  end

  // Inhibit, cycle overflow and pending bit.
  always_comb begin
    inh_d     = inh_q;
    cyc_ovf_d = cyc_ovf_q;
    pend_d    = pend_q;
    if (is_wr && (word_q == INH_W)) begin
      inh_d = data_q[NUM_CTRS-1:0];
    end
    if (cyc_ctl.wr_hi) begin
      cyc_ovf_d = data_q[31];
    end else if (cyc_wrap) begin
      cyc_ovf_d = 1'b1;
    end
    if (is_wr && (word_q == IPSR_W) && data_q[PMIP_BIT]) begin
      pend_d = 1'b0;
    end
    if ((cyc_wrap && !cyc_ovf_q) || (|slot_set)) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inh_q     <= '0;
      cyc_ovf_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      inh_q     <= inh_d;
      cyc_ovf_q <= cyc_ovf_d;
      pend_q    <= pend_d;
    end
  end

  // Read path.
  always_comb begin
    ovf_sum    = '0;
    ovf_sum[0] = cyc_ovf_q;
    for (int k = 0; k < NumEvt; k++) begin
      ovf_sum[k+1] = slot_ovf[k];
    end
  end

  always_comb begin
    rd_d = '0;
    if (kind_q == KIND_READ) begin
      priority if (word_q == IPSR_W) begin
        rd_d = {29'd0, pend_q, 2'd0};
      end else if (word_q == OVF_W) begin
        rd_d = ovf_sum;
      end else if (word_q == INH_W) begin
        rd_d = 32'(inh_q);
      end else if ((word_q == CYC_LO_W) || (word_q == CYC_HI_W)) begin
        rd_d = word_q[0] ? cyc64[63:32] : cyc64[31:0];
      end else if (in_ctr) begin
        for (int k = 0; k < NumEvt; k++) begin
          if (ctr_k == 7'(k)) begin
            rd_d = word_q[0] ? 32'(64'(slot_cnt[k]) >> 32) : 32'(64'(slot_cnt[k]));
          end
        end
      end else if (in_evt) begin
        for (int k = 0; k < NumEvt; k++) begin
          if (evt_k == 7'(k)) begin
            rd_d = word_q[0] ? {slot_ovf[k], slot_sel[k][SEL_BITS-1:32]}
                             : slot_sel[k][31:0];
          end
        end
      end else begin
        rd_d = '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      irq_q       <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
      irq_q       <= pend_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rd_q <= rd_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign irq_pending_o = irq_q;

`ifndef NO_ASSERTIONS
  a_pend_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(is_tick))
    else $error("pending bit raised without a tick");

  a_pend_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> $past(is_wr && (word_q == IPSR_W) && data_q[PMIP_BIT]))
    else $error("pending bit cleared without an ipsr write");

  a_cyc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(is_tick || is_wr) |=> $stable(cyc_count))
    else $error("cycle counter moved without a tick or write");

  a_cyc_ovf_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cyc_ovf_q) |-> $past(cyc_ctl.wr_hi))
    else $error("cycle overflow flag cleared without a write");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(data_q) && $stable(word_q)))
    else $error("input register lost an item during stall");
`endif

endmodule
